/* rtl/two_stacks_shared_buffer_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the two-stack shared buffer
// Concurrent checks sampled on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef TWO_STACKS_SHARED_BUFFER_ASSERT_SVH
`define TWO_STACKS_SHARED_BUFFER_ASSERT_SVH

`ifndef ASSERT_OFF
// Check that prop holds at every clock edge outside reset.
`define TSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that cond is never true outside reset.
`define TSB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define TSB_ASSERT(lbl, prop, msg)
`define TSB_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

/* rtl/tsb_pkg.sv */
// ---------------------------------------------------------------------------
// tsb_pkg
// Types, codes and defaults shared by the two-stack shared buffer.
// ---------------------------------------------------------------------------
`default_nettype none

package tsb_pkg;

  localparam int unsigned StoreDepthDef = 256;
  localparam int unsigned ValueBitsDef  = 32;
  localparam int unsigned CapBits       = 9;
  localparam int unsigned CountBits     = 9;
  localparam int unsigned OutBits       = 32;
  localparam logic [CapBits-1:0] CapReset = 9'd256;

  typedef enum logic [1:0] {
    REQ_PUSH_LOW  = 2'd0,
    REQ_PUSH_HIGH = 2'd1,
    REQ_POP_LOW   = 2'd2,
    REQ_POP_HIGH  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]                req_type;
    logic signed [OutBits-1:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [OutBits-1:0] low_top;
    logic signed [OutBits-1:0] high_top;
    logic [CountBits-1:0]      low_count;
    logic [CountBits-1:0]      high_count;
  } out_word_t;

  // Result handed from the controller to the output register.
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } res_t;

endpackage

`default_nettype wire

/* rtl/tsb_store.sv */
// ---------------------------------------------------------------------------
// tsb_store
// Shared stack storage: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module tsb_store #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [Width-1:0]    wdata_i,
  input  wire logic                re_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output      logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/tsb_ctrl.sv */
// ---------------------------------------------------------------------------
// tsb_ctrl
// Stack pointers, cached top values and store access sequencing.
// ---------------------------------------------------------------------------
`default_nettype none

module tsb_ctrl #(
  parameter int unsigned StoreDepth = 256,
  parameter int unsigned ValueBits  = 32,
  localparam int unsigned AddrBits  = (StoreDepth > 1) ? $clog2(StoreDepth) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output      logic                     in_ready_o,
  input  wire tsb_pkg::in_word_t        in_i,
  input  wire logic                     out_free_i,
  input  wire logic                     cfg_we_i,
  input  wire logic [tsb_pkg::CapBits-1:0] cfg_data_i,
  output      logic                     mem_we_o,
  output      logic [AddrBits-1:0]      mem_waddr_o,
  output      logic [ValueBits-1:0]     mem_wdata_o,
  output      logic                     mem_re_o,
  output      logic [AddrBits-1:0]      mem_raddr_o,
  input  wire logic [ValueBits-1:0]     mem_rdata_i,
  output      tsb_pkg::res_t            res_o
);
  import tsb_pkg::*;

  localparam logic [31:0] DepthW = 32'(StoreDepth);

  state_e               state_q, state_d;
  logic [CountBits-1:0] low_q, low_d, high_q, high_d;
  logic [CapBits-1:0]   cap_q, cap_d;
  logic [ValueBits-1:0] low_top_q, low_top_d, high_top_q, high_top_d;
  logic                 side_q, side_d;   // pending refill: 0 low, 1 high
  logic                 in_fire, read_go;
  logic                 full;
  status_e              stat;

  function automatic logic [CapBits-1:0] clip_cap(input logic [CapBits-1:0] v);
    clip_cap = ({23'd0, v} > DepthW) ? CapBits'(StoreDepth) : v;
  endfunction

  function automatic logic signed [OutBits-1:0] top_out(input logic [ValueBits-1:0] v,
                                                        input logic [CountBits-1:0] d);
    if (d == '0) begin
      top_out = '1;
    end else begin
      top_out = OutBits'(signed'(v));
    end
  endfunction

  assign in_fire = in_valid_i && in_ready_o;
  assign full    = ({1'b0, low_q} + {1'b0, high_q}) >= {1'b0, cap_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && read_go) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs: one item in flight; stall input while a refill read is pending or the output register is not free.
  always_comb begin
    in_ready_o = (state_q == S_IDLE) && out_free_i;
  end

  // Pointer, top and store access logic.
  always_comb begin
    low_d       = low_q;
    high_d      = high_q;
    cap_d       = cap_q;
    low_top_d   = low_top_q;
    high_top_d  = high_top_q;
    side_d      = side_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = ValueBits'($unsigned(in_i.push_value));
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    read_go     = 1'b0;
    stat        = STAT_DONE;

    if (state_q == S_READ) begin
      if (side_q) begin
        high_top_d = mem_rdata_i;
      end else begin
        low_top_d = mem_rdata_i;
      end
    end else if (in_fire) begin
      unique case (req_e'(in_i.req_type))
        REQ_PUSH_LOW: begin
          if (full) begin
            stat = STAT_FULL;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = AddrBits'(low_q);
            low_d       = low_q + 1'b1;
            low_top_d   = mem_wdata_o;
          end
        end
        REQ_PUSH_HIGH: begin
          if (full) begin
            stat = STAT_FULL;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = AddrBits'(cap_q - high_q - 1'b1);
            high_d      = high_q + 1'b1;
            high_top_d  = mem_wdata_o;
          end
        end
        REQ_POP_LOW: begin
          if (low_q == '0) begin
            stat = STAT_EMPTY;
          end else begin
            low_d = low_q - 1'b1;
            // Refill the cached top from the entry below.
            if (low_q > CountBits'(1)) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = AddrBits'(low_q - CountBits'(2));
              read_go     = 1'b1;
              side_d      = 1'b0;
            end
          end
        end
        REQ_POP_HIGH: begin
          if (high_q == '0) begin
            stat = STAT_EMPTY;
          end else begin
            high_d = high_q - 1'b1;
            if (high_q > CountBits'(1)) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = AddrBits'(cap_q - high_q + 1'b1);
              read_go     = 1'b1;
              side_d      = 1'b1;
            end
          end
        end
        default: stat = STAT_DONE;
      endcase
    end

    // A capacity write empties both stacks.
    if (cfg_we_i) begin
      cap_d  = clip_cap(cfg_data_i);
      low_d  = '0;
      high_d = '0;
    end
  end

  always_comb begin
    res_o.valid           = (in_fire && !read_go) || (state_q == S_READ);
    res_o.word.status     = stat;
    res_o.word.low_top    = top_out(low_top_d, low_d);
    res_o.word.high_top   = top_out(high_top_d, high_d);
    res_o.word.low_count  = low_d;
    res_o.word.high_count = high_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      low_q   <= '0;
      high_q  <= '0;
      cap_q   <= clip_cap(CapReset);
      side_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      low_q   <= low_d;
      high_q  <= high_d;
      cap_q   <= cap_d;
      side_q  <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_top_q  <= low_top_d;
    high_top_q <= high_top_d;
  end

endmodule

`default_nettype wire

/* rtl/two_stacks_shared_buffer.sv */
// ---------------------------------------------------------------------------
// two_stacks_shared_buffer
// Two LIFO stacks in one store: low grows up from 0, high grows down from
// the configured capacity.
// ---------------------------------------------------------------------------
//  channel  direction  handshake              word
//  in       input      in_valid_i/in_ready_o  in_i  (req_type, push_value)
//  out      output     out_valid_o/out_ready_i out_o (status, tops, counts)
//  cfg      input      cfg_we_i               cfg_data_i (capacity)
//
//  Push, refused request, or a pop that empties its stack: the result goes
//  straight to the output register. Pop that leaves its stack non-empty: the
//  result waits in S_READ on the store read that refills that stack's cached top.
//  Results sit in one output register; a new word is taken in the cycle that
//  register empties or is being emptied, so an output stall stalls the input.
//  Reset empties both stacks and sets capacity to 256 (limited to the store
//  depth); store contents are not cleared and are never read before written.
// ---------------------------------------------------------------------------
`default_nettype none
`include "two_stacks_shared_buffer_assert.svh"

module two_stacks_shared_buffer #(
  parameter int unsigned StoreDepth = tsb_pkg::StoreDepthDef,
  parameter int unsigned ValueBits  = tsb_pkg::ValueBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire tsb_pkg::in_word_t           in_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      tsb_pkg::out_word_t          out_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [tsb_pkg::CapBits-1:0] cfg_data_i
);
  import tsb_pkg::*;

  localparam int unsigned AddrBits = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  logic                 mem_we, mem_re;
  logic [AddrBits-1:0]  mem_waddr, mem_raddr;
  logic [ValueBits-1:0] mem_wdata, mem_rdata;
  res_t                 res;
  logic                 out_free;
  logic                 out_valid_q, out_valid_d;
  out_word_t            out_q;

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  tsb_ctrl #(
    .StoreDepth (StoreDepth),
    .ValueBits  (ValueBits)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_free_i  (out_free),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_o       (res)
  );

  tsb_store #(
    .Depth (StoreDepth),
    .Width (ValueBits)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Load a new result, drop the old one once taken, otherwise hold.
  always_comb begin
    priority if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_q <= res.word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A stalled result blocks new words.
  `TSB_ASSERT_NEVER(a_stall_blocks_input, out_valid_o && !out_ready_i && in_ready_o, "input taken while result stalled")
  // Every accepted word either shows a result next cycle or holds off input.
  `TSB_ASSERT(a_accept_progress, (in_valid_i && in_ready_o) |=> (out_valid_o || !in_ready_o), "accepted word made no progress")
  // An empty low stack reports all ones as its top.
  `TSB_ASSERT(a_empty_top, (out_valid_o && out_o.low_count == '0) |-> (out_o.low_top == '1), "empty low stack top not -1")
  // An empty refusal leaves at least one stack empty.
  `TSB_ASSERT(a_empty_refusal, (out_valid_o && out_o.status == STAT_EMPTY) |-> (out_o.low_count == '0 || out_o.high_count == '0), "empty refusal with both stacks non-empty")

endmodule

`default_nettype wire
